/* hw/rtl/gsbp_pkg.sv */
// Shared types, constants and the counter update function of the gselect branch predictor.
package gsbp_pkg;

  typedef logic [1:0] ctr_t;

  localparam logic [31:0] EvenMask = 32'h5555_5555;
  localparam logic [31:0] OddMask  = 32'hAAAA_AAAA;

  localparam logic KindFetch  = 1'b0;
  localparam logic KindRetire = 1'b1;

  localparam ctr_t CtrReset = 2'b00;
  localparam ctr_t CtrMax   = 2'b01;
  localparam ctr_t CtrMin   = 2'b10;

  function automatic ctr_t ctr_update(input ctr_t cur, input logic tk);
    ctr_t res;
    res = cur;
    if (tk) begin
      if (cur != CtrMax) res = cur + 2'd1;
    end else begin
      if (cur != CtrMin) res = cur - 2'd1;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/gsbp_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module gsbp_ram #(
  parameter int Width = 2,
  parameter int Depth = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gselect_branch_predictor_top.sv */
// Top level of the gselect branch predictor with a counter table in RAM.
//
// The predictor takes one micro-op request per cycle, fetch or retire, unless a held
// prediction or the table clear stalls it. The request's table index is formed at
// acceptance from the matching global history and the pc, and the counter RAM is
// read then; the request is registered in the read stage, from which a conditional
// fetch's prediction is loaded into the output register and a conditional retire's
// update is written back. A write that lands on the entry being read in the same
// cycle is forwarded. After reset the block sweeps the counter RAM to zero, one
// entry per cycle; no request is accepted during that sweep.
module gselect_branch_predictor_top import gsbp_pkg::*; #(
  parameter int INDEX_BITS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] pc_i,
  input  logic        is_conditional_i,
  input  logic        is_branch_i,
  input  logic        taken_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        predict_taken_o
);

  localparam int Depth = 2 ** INDEX_BITS;

  logic [INDEX_BITS:0]   clr_cnt_q, clr_cnt_d;
  logic                  clearing;
  logic [INDEX_BITS-1:0] fetch_hist_q, fetch_hist_d;
  logic [INDEX_BITS-1:0] retire_hist_q, retire_hist_d;
  logic [INDEX_BITS-1:0] sel_hist, upd_hist;
  logic [31:0]           idx_full;
  logic [INDEX_BITS-1:0] idx;
  logic                  accept, s1_adv;

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_retire_q, s1_cond_q, s1_taken_q;
  logic [INDEX_BITS-1:0] s1_idx_q;
  logic                  s1_fwd_q;
  ctr_t                  s1_fwd_data_q;

  logic                  out_valid_q, out_valid_d;
  logic                  pred_q, pred_d;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  ctr_t                  ram_wdata, ram_rdata, cur_ctr;

  assign clearing = !clr_cnt_q[INDEX_BITS];
  assign clr_cnt_d = clearing ? clr_cnt_q + {{INDEX_BITS{1'b0}}, 1'b1} : clr_cnt_q;

  assign s1_adv = !s1_valid_q || s1_retire_q || !s1_cond_q || !out_valid_q || out_ready_i;
  assign in_ready_o = !clearing && s1_adv;
  assign accept = in_valid_i && in_ready_o;

  assign sel_hist = (kind_i == KindRetire) ? retire_hist_q : fetch_hist_q;
  assign idx_full = (32'(sel_hist) & EvenMask) | (pc_i & OddMask);
  assign idx = idx_full[INDEX_BITS-1:0];

  always_comb begin
    upd_hist = sel_hist;
    if (is_conditional_i) begin
      upd_hist = {sel_hist[INDEX_BITS-2:0], taken_i};
    end else if (is_branch_i) begin
      upd_hist = {sel_hist[INDEX_BITS-2:0], 1'b1};
    end
    fetch_hist_d = fetch_hist_q;
    retire_hist_d = retire_hist_q;
    if (accept && kind_i == KindRetire) retire_hist_d = upd_hist;
    if (accept && kind_i == KindFetch) fetch_hist_d = upd_hist;
  end

  assign cur_ctr = s1_fwd_q ? s1_fwd_data_q : ram_rdata;

  always_comb begin
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt_q[INDEX_BITS-1:0];
      ram_wdata = CtrReset;
    end else begin
      ram_we = s1_valid_q && s1_retire_q && s1_cond_q;
      ram_waddr = s1_idx_q;
      ram_wdata = ctr_update(cur_ctr, s1_taken_q);
    end
  end

  always_comb begin
    s1_valid_d = s1_adv ? accept : s1_valid_q;
    out_valid_d = out_valid_q;
    pred_d = pred_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (s1_valid_q && !s1_retire_q && s1_cond_q && s1_adv) begin
      out_valid_d = 1'b1;
      pred_d = !cur_ctr[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      fetch_hist_q <= '0;
      retire_hist_q <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      fetch_hist_q <= fetch_hist_d;
      retire_hist_q <= retire_hist_d;
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pred_q <= pred_d;
    if (accept) begin
      s1_retire_q <= (kind_i == KindRetire);
      s1_cond_q <= is_conditional_i;
      s1_taken_q <= taken_i;
      s1_idx_q <= idx;
      s1_fwd_q <= ram_we && (ram_waddr == idx);
      s1_fwd_data_q <= ram_wdata;
    end
  end

  gsbp_ram #(
    .Width($bits(ctr_t)),
    .Depth(Depth)
  ) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign predict_taken_o = pred_q;

`ifndef SYNTHESIS
  // No request may be taken while the table is being cleared.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept) else $error("request accepted during table clear");

  // The clearing sweep and a pipeline item never compete for the write port.
  a_clear_s1_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clearing && s1_valid_q)) else $error("pipeline busy during table clear");

  // A new prediction only comes from a fetched conditional branch in the read stage.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && !s1_retire_q && s1_cond_q))
    else $error("prediction without a fetched conditional branch");
`endif

endmodule
